>>> hdl/ftb_pkg.sv
// Shared constants and types for the face tangent/bitangent block.
`timescale 1ns / 1ps
package ftb_pkg;
   localparam int PositionWidthDef  = 24;
   localparam int TexcoordWidthDef  = 20;
   localparam int OutputFracBitsDef = 16;
   localparam int CornersPerFace    = 3;
   localparam int DeltaMaxWidth     = 31;   // deltas are shifted to fit 31 bits signed
   localparam int ProdWidth         = 64;
   localparam int MagWidth          = 30;   // normalised magnitude width
   localparam int SumWidth          = 62;   // three squares of 30 bits

   // arithmetic unit operations
   typedef enum logic [1:0] {
      OP_MUL_SUB = 2'd0,
      OP_SQRT    = 2'd1,
      OP_DIV     = 2'd2
   } op_type;

   typedef struct packed {
      logic  start;
      op_type op;
   } unit_ctl_type;
endpackage

>>> hdl/ftb_unit.sv
// Shared iterative unit: restoring square root and divider, one bit a cycle.
`timescale 1ns / 1ps
module ftb_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  ftb_pkg::unit_ctl_type         ctl,
   input  logic [ftb_pkg::SumWidth-1:0]  opa,
   input  logic [ftb_pkg::SumWidth-1:0]  opb,
   output logic                          done,
   output logic [ftb_pkg::SumWidth-1:0]  result
);
   import ftb_pkg::*;

   localparam int CntW = $clog2(SumWidth + 1);

   logic [SumWidth-1:0]   rem_ff, rem_in;
   logic [SumWidth-1:0]   num_ff, num_in;
   logic [SumWidth-1:0]   den_ff, den_in;
   logic [SumWidth-1:0]   res_ff, res_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  sqrt_ff, sqrt_in;
   logic [SumWidth+1:0]   trial;
   logic [SumWidth+1:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      shifted = '0;
      trial   = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         sqrt_in = (ctl.op == OP_SQRT);
         rem_in  = '0;
         res_in  = '0;
         num_in  = opa;
         den_in  = opb;
         cnt_in  = (ctl.op == OP_SQRT) ? CntW'(SumWidth / 2) : CntW'(SumWidth);
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            // two radicand bits in, one root bit out
            shifted = {rem_ff, num_ff[SumWidth-1 -: 2]};
            trial   = {res_ff, 2'b01};
            num_in  = {num_ff[SumWidth-3:0], 2'b00};
         end else begin
            shifted = {1'b0, rem_ff, num_ff[SumWidth-1]};
            trial   = {2'b00, den_ff};
            num_in  = {num_ff[SumWidth-2:0], 1'b0};
         end
         if (shifted >= trial) begin
            rem_in = SumWidth'(shifted - trial);
            res_in = {res_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = SumWidth'(shifted);
            res_in = {res_ff[SumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
      sqrt_ff <= sqrt_in;
   end

   assign done   = busy_ff && (cnt_ff == CntW'(1));
   assign result = res_in;
endmodule

>>> hdl/face_tangent_bitangent.sv
// Top level: per-face unit tangent and bitangent from three streamed corners.
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_pos_x/y/z, req_tex_u/v
//  rsp     | out | rsp_valid, rsp_stall, rsp_tangent_*, rsp_bitangent_*, rsp_degenerate
// The first two corners of a face are only held; accepting the third forms the deltas.
// After the third corner the block computes 14 products, then per vector up to 29
// normalising shifts, a 31-step square root and three 62-step divisions in the shared unit.
// A degenerate face skips what is left and finishes sooner.
// Synchronous reset clears the corner count, sequencer and output valid; the held corners need none.
// req_stall stays high while a face computes or its word waits on rsp_stall.
`timescale 1ns / 1ps
module face_tangent_bitangent #(
   parameter int POSITION_WIDTH   = ftb_pkg::PositionWidthDef,
   parameter int TEXCOORD_WIDTH   = ftb_pkg::TexcoordWidthDef,
   parameter int OUTPUT_FRAC_BITS = ftb_pkg::OutputFracBitsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_x,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_y,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_z,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_u,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_v,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_tangent_x,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_tangent_y,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_tangent_z,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_bitangent_x,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_bitangent_y,
   output logic signed [OUTPUT_FRAC_BITS+1:0] rsp_bitangent_z,
   output logic                          rsp_degenerate
);
   import ftb_pkg::*;

   localparam int OW    = OUTPUT_FRAC_BITS + 2;
   localparam int PSh   = (POSITION_WIDTH > 30) ? POSITION_WIDTH - 30 : 0;
   localparam int TSh   = (TEXCOORD_WIDTH > 30) ? TEXCOORD_WIDTH - 30 : 0;
   localparam int PDW   = POSITION_WIDTH + 1 - PSh;   // delta widths after shift
   localparam int TDW   = TEXCOORD_WIDTH + 1 - TSh;
   localparam int BW    = (PDW > TDW) ? PDW : TDW;    // second multiplier operand
   // product magnitude bound, never narrower than the normalised range
   localparam int MW    = (PDW + TDW + 1 > MagWidth) ? PDW + TDW + 1 : MagWidth + 1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_MUL   = 11'b00000000010,
      ST_ABS   = 11'b00000000100,
      ST_NORM  = 11'b00000001000,
      ST_SQ    = 11'b00000010000,
      ST_SQRT  = 11'b00000100000,
      ST_SQW   = 11'b00001000000,
      ST_DIV   = 11'b00010000000,
      ST_DIVW  = 11'b00100000000,
      ST_NEXT  = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] count_ff, count_in;

   // held corners
   logic signed [POSITION_WIDTH-1:0] hp_ff [6];
   logic signed [TEXCOORD_WIDTH-1:0] ht_ff [4];
   logic [2:0] hp_base;
   logic [1:0] ht_base;
   // deltas of the face
   logic signed [PDW-1:0] e1_ff [3], e2_ff [3];
   logic signed [TDW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   // vectors: index 0..2 tangent, 3..5 bitangent; det in slot 6
   logic signed [ProdWidth-1:0] vec_ff [7];
   logic [3:0] step_ff, step_in;            // product sequencing
   logic signed [ProdWidth-1:0] acc_ff;
   logic signed [TDW-1:0]       mul_a;
   logic signed [BW-1:0]        mul_b;
   logic signed [TDW+BW-1:0]    prod_n;
   logic signed [ProdWidth-1:0] prod;

   logic       which_ff;                    // 0 tangent, 1 bitangent
   logic [MW-1:0] mag_ff [3];
   logic [1:0] comp_ff;
   logic [SumWidth-1:0] sum_ff, len_ff;
   logic [OW-1:0] res_ff [6];
   logic degen_ff, flip_ff;
   logic rsp_valid_ff;

   unit_ctl_type ctl;
   logic [SumWidth-1:0] opa, opb, ures;
   logic udone;

   ftb_unit u_unit (
      .clock (clock), .reset (reset), .ctl (ctl),
      .opa (opa), .opb (opb), .done (udone), .result (ures)
   );

   logic accept;
   assign req_stall = !(state_ff == ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign hp_base = count_ff[0] ? 3'd3 : 3'd0;
   assign ht_base = {count_ff[0], 1'b0};

   // product schedule operands: one multiply per cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         4'd0:  begin mul_a = du1_ff; mul_b = BW'(dv2_ff); end
         4'd1:  begin mul_a = du2_ff; mul_b = BW'(dv1_ff); end
         4'd2:  begin mul_a = dv2_ff; mul_b = BW'(e1_ff[0]); end
         4'd3:  begin mul_a = dv1_ff; mul_b = BW'(e2_ff[0]); end
         4'd4:  begin mul_a = dv2_ff; mul_b = BW'(e1_ff[1]); end
         4'd5:  begin mul_a = dv1_ff; mul_b = BW'(e2_ff[1]); end
         4'd6:  begin mul_a = dv2_ff; mul_b = BW'(e1_ff[2]); end
         4'd7:  begin mul_a = dv1_ff; mul_b = BW'(e2_ff[2]); end
         4'd8:  begin mul_a = du1_ff; mul_b = BW'(e2_ff[0]); end
         4'd9:  begin mul_a = du2_ff; mul_b = BW'(e1_ff[0]); end
         4'd10: begin mul_a = du1_ff; mul_b = BW'(e2_ff[1]); end
         4'd11: begin mul_a = du2_ff; mul_b = BW'(e1_ff[1]); end
         4'd12: begin mul_a = du1_ff; mul_b = BW'(e2_ff[2]); end
         4'd13: begin mul_a = du2_ff; mul_b = BW'(e1_ff[2]); end
         default: ;
      endcase
   end
   assign prod_n = mul_a * mul_b;   // operands at most 31 bits wide
   assign prod   = ProdWidth'(prod_n);

   logic [2:0]  vsel;
   logic [MW-1:0] top_mag;
   logic [MagWidth-1:0] m0, m1, m2, mc;
   assign vsel = which_ff ? 3'd3 : 3'd0;
   assign m0 = MagWidth'(mag_ff[0]);
   assign m1 = MagWidth'(mag_ff[1]);
   assign m2 = MagWidth'(mag_ff[2]);
   assign mc = (comp_ff == 2'd0) ? m0 : (comp_ff == 2'd1) ? m1 : m2;
   always_comb begin
      top_mag = mag_ff[0] | mag_ff[1] | mag_ff[2];
   end

   logic [ProdWidth-1:0] abs_v [3];
   logic [2:0] vidx;
   assign vidx = vsel + 3'(comp_ff);
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = vec_ff[vsel + 3'(i)][ProdWidth-1] ? ProdWidth'(-vec_ff[vsel + 3'(i)])
                                                      : ProdWidth'(vec_ff[vsel + 3'(i)]);
      end
   end

   logic [2*MagWidth-1:0] sq_n;
   logic [SumWidth-1:0] sq;
   assign sq_n = mc * mc;
   assign sq   = SumWidth'(sq_n);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      ctl      = '{start: 1'b0, op: OP_MUL_SUB};
      opa      = '0;
      opb      = '0;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            if (count_ff >= 2'(CornersPerFace - 1)) begin
               count_in = '0;
               state_in = ST_MUL;
               step_in  = '0;
            end else count_in = count_ff + 1'b1;
         end
         ST_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd13) state_in = ST_ABS;
         end
         ST_ABS: state_in = ST_NORM;
         ST_NORM: begin
            // zero det or zero vector: nothing more to compute
            if (top_mag == '0 || degen_ff) state_in = ST_OUT;
            else if (top_mag[MW-1:MagWidth] == '0 && top_mag[MagWidth-1])
               state_in = ST_SQ;
         end
         ST_SQ: if (comp_ff == 2'd2) state_in = ST_SQRT;
         ST_SQRT: begin
            ctl = '{start: 1'b1, op: OP_SQRT};
            opa = sum_ff;
            state_in = ST_SQW;
         end
         ST_SQW: if (udone) state_in = ST_DIV;
         ST_DIV: begin
            ctl = '{start: 1'b1, op: OP_DIV};
            opa = SumWidth'({mc, OUTPUT_FRAC_BITS'(0)}) + (len_ff >> 1);
            opb = len_ff;
            state_in = ST_DIVW;
         end
         ST_DIVW: if (udone) state_in = (comp_ff == 2'd2) ? ST_NEXT : ST_DIV;
         ST_NEXT: state_in = which_ff ? ST_OUT : ST_ABS;
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      step_ff <= step_in;

      if (accept) begin
         if (count_ff < 2'(CornersPerFace - 1)) begin
            hp_ff[hp_base]        <= req_pos_x;
            hp_ff[hp_base + 3'd1] <= req_pos_y;
            hp_ff[hp_base + 3'd2] <= req_pos_z;
            ht_ff[ht_base]        <= req_tex_u;
            ht_ff[ht_base + 2'd1] <= req_tex_v;
         end else begin
            e1_ff[0] <= PDW'(((POSITION_WIDTH+1)'(hp_ff[3]) - (POSITION_WIDTH+1)'(hp_ff[0]))
                        >>> PSh);
            e1_ff[1] <= PDW'(((POSITION_WIDTH+1)'(hp_ff[4]) - (POSITION_WIDTH+1)'(hp_ff[1]))
                        >>> PSh);
            e1_ff[2] <= PDW'(((POSITION_WIDTH+1)'(hp_ff[5]) - (POSITION_WIDTH+1)'(hp_ff[2]))
                        >>> PSh);
            e2_ff[0] <= PDW'(((POSITION_WIDTH+1)'(req_pos_x) - (POSITION_WIDTH+1)'(hp_ff[0]))
                        >>> PSh);
            e2_ff[1] <= PDW'(((POSITION_WIDTH+1)'(req_pos_y) - (POSITION_WIDTH+1)'(hp_ff[1]))
                        >>> PSh);
            e2_ff[2] <= PDW'(((POSITION_WIDTH+1)'(req_pos_z) - (POSITION_WIDTH+1)'(hp_ff[2]))
                        >>> PSh);
            du1_ff <= TDW'(((TEXCOORD_WIDTH+1)'(ht_ff[2]) - (TEXCOORD_WIDTH+1)'(ht_ff[0]))
                      >>> TSh);
            dv1_ff <= TDW'(((TEXCOORD_WIDTH+1)'(ht_ff[3]) - (TEXCOORD_WIDTH+1)'(ht_ff[1]))
                      >>> TSh);
            du2_ff <= TDW'(((TEXCOORD_WIDTH+1)'(req_tex_u) - (TEXCOORD_WIDTH+1)'(ht_ff[0]))
                      >>> TSh);
            dv2_ff <= TDW'(((TEXCOORD_WIDTH+1)'(req_tex_v) - (TEXCOORD_WIDTH+1)'(ht_ff[1]))
                      >>> TSh);
            which_ff <= 1'b0;
            degen_ff <= 1'b0;
         end
      end

      // accumulate pairs: even step loads, odd step subtracts
      if (state_ff == ST_MUL) begin
         if (!step_ff[0]) acc_ff <= prod;
         else vec_ff[(step_ff == 4'd1) ? 3'd6 : 3'(step_ff[3:1] - 3'd1)] <= acc_ff - prod;
      end

      // magnitudes of the chosen vector, all three at once
      if (state_ff == ST_ABS) begin
         for (int i = 0; i < 3; i++) mag_ff[i] <= MW'(abs_v[i]);
         flip_ff <= vec_ff[6][ProdWidth-1];
         if (vec_ff[6] == '0) degen_ff <= 1'b1;
         sum_ff <= '0;
      end

      // one shift a cycle until the largest magnitude lies in [2^29, 2^30)
      if (state_ff == ST_NORM) begin
         comp_ff <= 2'd0;
         if (top_mag == '0 || degen_ff) degen_ff <= 1'b1;
         else if (top_mag[MW-1:MagWidth] != '0) begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end else if (!top_mag[MagWidth-1]) begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
         end
      end
      if (state_ff == ST_SQ) begin
         sum_ff  <= sum_ff + sq;
         comp_ff <= comp_ff + 1'b1;
      end
      if (state_ff == ST_SQW && udone) begin
         len_ff  <= ures;
         comp_ff <= 2'd0;
      end
      if (state_ff == ST_DIVW && udone) begin
         res_ff[vsel + 3'(comp_ff)] <=
            (((vec_ff[vidx] < 0) != flip_ff) ? OW'(-ures) : OW'(ures));
         comp_ff <= comp_ff + 1'b1;
      end
      if (state_ff == ST_NEXT) begin
         which_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_degenerate  = degen_ff;
   assign rsp_tangent_x   = degen_ff ? '0 : res_ff[0];
   assign rsp_tangent_y   = degen_ff ? '0 : res_ff[1];
   assign rsp_tangent_z   = degen_ff ? '0 : res_ff[2];
   assign rsp_bitangent_x = degen_ff ? '0 : res_ff[3];
   assign rsp_bitangent_y = degen_ff ? '0 : res_ff[4];
   assign rsp_bitangent_z = degen_ff ? '0 : res_ff[5];
endmodule

>>> hdl/ftb_checker.sv
// Port-level checker for the face tangent/bitangent block, with its bind.
`timescale 1ns / 1ps
module ftb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_degenerate,
   input logic [17:0] rsp_tangent_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tangent_x))
      else $error("stalled word changed");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while word pending");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent_x == '0)
      else $error("degenerate word not zero");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled input word dropped");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word after reset");
endmodule

bind face_tangent_bitangent ftb_checker u_ftb_checker (
   .clock (clock), .reset (reset), .req_valid (req_valid), .req_stall (req_stall),
   .rsp_valid (rsp_valid), .rsp_stall (rsp_stall), .rsp_degenerate (rsp_degenerate),
   .rsp_tangent_x (rsp_tangent_x)
);
